/* rtl/beep_pattern_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// Beep pattern sequencer assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BEEP_PATTERN_SEQUENCER_DEFINES_SVH
`define BEEP_PATTERN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// Beep pattern sequencer package
// Request and result types, codes, register defaults and the pattern ROM.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Request kinds carried in req_type; the fourth code is ignored.
  typedef enum logic [1:0] {
    ReqTick    = 2'd0,
    ReqBuiltin = 2'd1,
    ReqCustom  = 2'd2
  } req_type_e;

  // Request result codes.
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StParam = 2'd1,
    StBusy  = 2'd2
  } status_e;

  // Symbol codes, two bits each, first symbol in the lowest bits.
  typedef enum logic [1:0] {
    CodeEnd  = 2'd0,
    CodeDot  = 2'd1,
    CodeDash = 2'd2,
    CodeSkip = 2'd3
  } code_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgDot  = 2'd0;
  localparam logic [1:0] CfgDash = 2'd1;
  localparam logic [1:0] CfgGap  = 2'd2;

  localparam logic [15:0] DotReset  = 16'd40;
  localparam logic [15:0] DashReset = 16'd120;
  localparam logic [15:0] GapReset  = 16'd40;

  // Built-in patterns occupy indexes below this; this index is the custom slot.
  localparam logic [7:0] CustomSlot = 8'd8;
  // Symbol words never index past this many codes.
  localparam int unsigned WordSymbols = 16;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  pattern_sel;
    logic [31:0] custom_pattern;
  } item_t;

  typedef struct packed {
    logic       tone_on;
    logic       busy_res;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [15:0] dot_duration;
    logic [15:0] dash_duration;
    logic [15:0] gap_duration;
  } cfg_t;

  typedef struct packed {
    logic playing;
    logic sounding;
  } play_state_t;

  // Built-in pattern ROM.
  function automatic logic [31:0] builtin_pattern(logic [2:0] idx);
    logic [31:0] pat;
    unique case (idx)
      3'd0:    pat = 32'h0000_0001;  // .
      3'd1:    pat = 32'h0000_0099;  // .-.-
      3'd2:    pat = 32'h0000_0026;  // -.-
      3'd3:    pat = 32'h0000_002A;  // ---
      3'd4:    pat = 32'h0000_0001;  // .
      3'd5:    pat = 32'h0000_0005;  // ..
      3'd6:    pat = 32'h0000_0015;  // ...
      default: pat = 32'h0000_0009;  // .-
    endcase
    return pat;
  endfunction

endpackage

/* rtl/beep_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// Beep pattern sequencer
// Plays dot and dash buzzer patterns driven by millisecond tick requests.
// ----------------------------------------------------------------------------
//  Channel  Handshake                      Payload
//  in       in_valid_i / in_ready_o        req_type_i, pattern_sel_i, custom_pattern_i
//  out      out_valid_o / out_ready_i      tone_on_o, busy_res_o, status_o
//  cfg      cfg_we_i (no wait)             cfg_idx_i, cfg_wdata_i
//
//  One request per cycle sustained while the output is not stalled; each
//  accepted request passes the input register, then the result register.
//  The state update for a request is one countdown step or reload in the core.
//  Reset clears the playback state and loads the default durations.
//  A stalled output holds its result while one more request waits in the
//  input register; further requests are held off by in_ready_o.
module beep_pattern_sequencer #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  pattern_sel_i,
  input  logic [31:0] custom_pattern_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tone_on_o,
  output logic        busy_res_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  `include "beep_pattern_sequencer_defines.svh"

  // Symbols past MAX_SYMBOLS, and always those past the sixteenth, end the pattern.
  localparam int unsigned SymLimit =
    (MAX_SYMBOLS < bps_pkg::WordSymbols) ? MAX_SYMBOLS : bps_pkg::WordSymbols;

  bps_pkg::item_t       in_item, stage_item;
  bps_pkg::result_t     core_result, out_result;
  bps_pkg::play_state_t play_state;
  bps_pkg::cfg_t        cfg_q, cfg_d;
  logic                 stage_valid, out_free, fire;

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bps_pkg::CfgDot:  cfg_d.dot_duration  = cfg_wdata_i;
        bps_pkg::CfgDash: cfg_d.dash_duration = cfg_wdata_i;
        bps_pkg::CfgGap:  cfg_d.gap_duration  = cfg_wdata_i;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_duration  <= bps_pkg::DotReset;
      cfg_q.dash_duration <= bps_pkg::DashReset;
      cfg_q.gap_duration  <= bps_pkg::GapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item.req_type       = req_type_i;
  assign in_item.pattern_sel    = pattern_sel_i;
  assign in_item.custom_pattern = custom_pattern_i;

  // A request is processed when its result has a place to go.
  assign fire = stage_valid && out_free;

  bps_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item),
    .advance_i     (out_free),
    .stage_valid_o (stage_valid),
    .stage_item_o  (stage_item)
  );

  bps_core #(
    .SYM_LIMIT (SymLimit)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .cfg_i    (cfg_q),
    .result_o (core_result),
    .state_o  (play_state)
  );

  bps_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (stage_valid),
    .load_result_i (core_result),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_result_o  (out_result)
  );

  assign tone_on_o  = out_result.tone_on;
  assign busy_res_o = out_result.busy_res;
  assign status_o   = out_result.status;

  // The tone only sounds inside a playing pattern.
  `BPS_ASSERT_NOW(a_tone_needs_play, !play_state.playing, !play_state.sounding, "tone on while idle")
  `BPS_ASSERT_NOW(a_out_tone_busy, out_valid_o && tone_on_o, busy_res_o, "result tone without busy")
  // A busy rejection is only given while a pattern plays.
  `BPS_ASSERT_NOW(a_busy_status, out_valid_o && (status_o == bps_pkg::StBusy), busy_res_o,
                  "busy status while idle")
  // A processed request always lands in the result register.
  `BPS_ASSERT_NEXT(a_fire_result, fire, out_valid_o, "processed request lost")

endmodule

/* rtl/bps_in_stage.sv */
// ----------------------------------------------------------------------------
// Beep pattern sequencer input stage
// Registers one request and holds it until the core can take it.
// ----------------------------------------------------------------------------
module bps_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bps_pkg::item_t in_item_i,
  input  logic           advance_i,
  output logic           stage_valid_o,
  output bps_pkg::item_t stage_item_o
);

  logic           valid_q, valid_d;
  bps_pkg::item_t item_q;

  // The register frees up whenever its request moves on in the same cycle.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_item_o  = item_q;

endmodule

/* rtl/bps_core.sv */
// ----------------------------------------------------------------------------
// Beep pattern sequencer core
// Holds the playback state and applies one tick or request per cycle when fire_i is set.
// ----------------------------------------------------------------------------
module bps_core #(
  parameter int unsigned SYM_LIMIT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  bps_pkg::item_t       item_i,
  input  bps_pkg::cfg_t        cfg_i,
  output bps_pkg::result_t     result_o,
  output bps_pkg::play_state_t state_o
);

  localparam int unsigned IdxW     = $clog2(SYM_LIMIT + 1);
  localparam int unsigned CodeIdxW = $clog2(SYM_LIMIT);

  logic            playing_q, playing_d;
  logic            sounding_q, sounding_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     rem_q, rem_d;
  logic [31:0]     active_q, active_d;

  logic [15:0]       rem_dec;
  bps_pkg::code_e    code;
  bps_pkg::status_e  status;

  assign rem_dec = rem_q - 16'd1;

  // Current symbol; past the last allowed position the pattern ends.
  always_comb begin
    if (idx_q >= IdxW'(SYM_LIMIT)) begin
      code = bps_pkg::CodeEnd;
    end else begin
      code = bps_pkg::code_e'(active_q[{idx_q[CodeIdxW-1:0], 1'b0} +: 2]);
    end
  end

  // Next state and request status.
  always_comb begin
    playing_d  = playing_q;
    sounding_d = sounding_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    active_d   = active_q;
    status     = bps_pkg::StOk;
    if (fire_i) begin
      unique case (bps_pkg::req_type_e'(item_i.req_type))
        bps_pkg::ReqTick: begin
          if (playing_q) begin
            if (rem_q != 16'd0 && rem_dec != 16'd0) begin
              rem_d = rem_dec;
            end else if (sounding_q) begin
              // Tone phase over: start the silent gap.
              sounding_d = 1'b0;
              rem_d      = cfg_i.gap_duration;
              idx_d      = idx_q + IdxW'(1);
            end else begin
              unique case (code)
                bps_pkg::CodeEnd: begin
                  playing_d  = 1'b0;
                  sounding_d = 1'b0;
                  idx_d      = '0;
                  active_d   = '0;
                  rem_d      = '0;
                end
                bps_pkg::CodeDot: begin
                  sounding_d = 1'b1;
                  rem_d      = cfg_i.dot_duration;
                end
                bps_pkg::CodeDash: begin
                  sounding_d = 1'b1;
                  rem_d      = cfg_i.dash_duration;
                end
                default: begin
                  // Skip code takes this one tick with the tone off.
                  idx_d = idx_q + IdxW'(1);
                  rem_d = '0;
                end
              endcase
            end
          end
        end
        bps_pkg::ReqBuiltin: begin
          if (item_i.pattern_sel > bps_pkg::CustomSlot) begin
            status = bps_pkg::StParam;
          end else if (playing_q) begin
            status = bps_pkg::StBusy;
          end else if (item_i.pattern_sel == bps_pkg::CustomSlot) begin
            status = bps_pkg::StParam;
          end else begin
            active_d   = bps_pkg::builtin_pattern(item_i.pattern_sel[2:0]);
            idx_d      = '0;
            playing_d  = 1'b1;
            sounding_d = 1'b0;
            rem_d      = '0;
          end
        end
        bps_pkg::ReqCustom: begin
          if (playing_q) begin
            status = bps_pkg::StBusy;
          end else if (item_i.custom_pattern[1:0] == bps_pkg::CodeEnd) begin
            status = bps_pkg::StParam;
          end else begin
            active_d   = item_i.custom_pattern;
            idx_d      = '0;
            playing_d  = 1'b1;
            sounding_d = 1'b0;
            rem_d      = '0;
          end
        end
        default: begin
          // Unused request type leaves everything as it is.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q  <= 1'b0;
      sounding_q <= 1'b0;
      idx_q      <= '0;
      rem_q      <= '0;
      active_q   <= '0;
    end else begin
      playing_q  <= playing_d;
      sounding_q <= sounding_d;
      idx_q      <= idx_d;
      rem_q      <= rem_d;
      active_q   <= active_d;
    end
  end

  // The result reflects the state after this request.
  assign result_o.tone_on  = sounding_d;
  assign result_o.busy_res = playing_d;
  assign result_o.status   = status;

  assign state_o.playing  = playing_q;
  assign state_o.sounding = sounding_q;

endmodule

/* rtl/bps_out_stage.sv */
// ----------------------------------------------------------------------------
// Beep pattern sequencer output stage
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module bps_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  input  bps_pkg::result_t load_result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bps_pkg::result_t out_result_o
);

  logic             valid_q, valid_d;
  bps_pkg::result_t result_q;

  // Free when empty or when the held result leaves this cycle.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_valid_i) begin
      result_q <= load_result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Beep pattern sequencer testbench
// Drives tick, built-in and custom play requests through the valid/ready
// input, predicts the buzzer level, busy flag and status of every request,
// and checks each result in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxSymbols  = 16;
  localparam int          HoldCycles  = 64;
  localparam int          QuietLimit  = 2000;
  localparam logic [1:0]  ReqIgnored  = 2'd3;

  // Built-in symbol words, entry 7 first.
  localparam logic [7:0][31:0] BuiltinSymbols = {
    32'h0000_0009, 32'h0000_0015, 32'h0000_0005, 32'h0000_0001,
    32'h0000_002A, 32'h0000_0026, 32'h0000_0099, 32'h0000_0001
  };

  typedef enum int {ReadyAlways, ReadyHalf, ReadyQuarter, ReadyRuns} ready_mode_e;

  // Tracks the sequencer state and the queue of expected results.
  class beep_tracker;
    logic [15:0]      dot_len;
    logic [15:0]      dash_len;
    logic [15:0]      gap_len;
    logic             playing;
    logic             sounding;
    logic [4:0]       sym_idx;
    logic [15:0]      ticks_left;
    logic [31:0]      symbols;
    bps_pkg::result_t expected_beeps[$];
    int               mismatches;
    int               checked;
    int               started;
    int               busy_rejects;
    int               param_rejects;
    int               tone_results;

    function new();
      dot_len    = bps_pkg::DotReset;
      dash_len   = bps_pkg::DashReset;
      gap_len    = bps_pkg::GapReset;
      playing    = 1'b0;
      sounding   = 1'b0;
      sym_idx    = '0;
      ticks_left = '0;
      symbols    = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] val);
      case (idx)
        bps_pkg::CfgDot:  dot_len = val;
        bps_pkg::CfgDash: dash_len = val;
        bps_pkg::CfgGap:  gap_len = val;
        default: ;
      endcase
    endfunction

    // Symbols at or past the word size end the pattern.
    function bps_pkg::code_e symbol_at(logic [4:0] idx);
      if (idx >= bps_pkg::WordSymbols || idx >= MaxSymbols) return bps_pkg::CodeEnd;
      return bps_pkg::code_e'(symbols[2*idx +: 2]);
    endfunction

    function void start_pattern(logic [31:0] word);
      symbols    = word;
      sym_idx    = '0;
      playing    = 1'b1;
      sounding   = 1'b0;
      ticks_left = '0;
      started++;
    endfunction

    // One millisecond of countdown; a finished phase hands over on the same tick.
    function void count_tick();
      bps_pkg::code_e c;
      if (!playing) return;
      if (ticks_left != 0) begin
        ticks_left = ticks_left - 16'd1;
        if (ticks_left != 0) return;
      end
      if (!sounding) begin
        c = symbol_at(sym_idx);
        if (c == bps_pkg::CodeEnd) begin
          playing    = 1'b0;
          sounding   = 1'b0;
          sym_idx    = '0;
          symbols    = '0;
          ticks_left = '0;
        end else if (c == bps_pkg::CodeDot || c == bps_pkg::CodeDash) begin
          sounding   = 1'b1;
          ticks_left = (c == bps_pkg::CodeDot) ? dot_len : dash_len;
        end else begin
          sym_idx    = sym_idx + 5'd1;
          ticks_left = '0;
        end
      end else begin
        sounding   = 1'b0;
        ticks_left = gap_len;
        sym_idx    = sym_idx + 5'd1;
      end
    endfunction

    function void note_request(bps_pkg::item_t req);
      bps_pkg::status_e st;
      bps_pkg::result_t exp;
      st = bps_pkg::StOk;
      case (req.req_type)
        bps_pkg::ReqTick: count_tick();
        bps_pkg::ReqBuiltin: begin
          // An index above the custom slot is refused even while busy.
          if (req.pattern_sel > bps_pkg::CustomSlot) st = bps_pkg::StParam;
          else if (playing) st = bps_pkg::StBusy;
          else if (req.pattern_sel == bps_pkg::CustomSlot) st = bps_pkg::StParam;
          else start_pattern(BuiltinSymbols[req.pattern_sel[2:0]]);
        end
        bps_pkg::ReqCustom: begin
          if (playing) st = bps_pkg::StBusy;
          else if (req.custom_pattern[1:0] == bps_pkg::CodeEnd) st = bps_pkg::StParam;
          else start_pattern(req.custom_pattern);
        end
        default: ;
      endcase
      if (st == bps_pkg::StBusy) busy_rejects++;
      if (st == bps_pkg::StParam) param_rejects++;
      exp.tone_on  = sounding;
      exp.busy_res = playing;
      exp.status   = st;
      expected_beeps.push_back(exp);
    endfunction

    function void check_result(bps_pkg::result_t got);
      bps_pkg::result_t exp;
      if (expected_beeps.size() == 0) begin
        $error("result with nothing expected: tone_on %0b busy_res %0b status %0d",
               got.tone_on, got.busy_res, got.status);
        mismatches++;
        return;
      end
      exp = expected_beeps.pop_front();
      checked++;
      if (got.tone_on === 1'b1) tone_results++;
      if (got.tone_on !== exp.tone_on) begin
        $error("tone_on: expected %0b, got %0b", exp.tone_on, got.tone_on);
        mismatches++;
      end
      if (got.busy_res !== exp.busy_res) begin
        $error("busy_res: expected %0b, got %0b", exp.busy_res, got.busy_res);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_beeps.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type = bps_pkg::ReqTick;
  logic [7:0]  pattern_sel = '0;
  logic [31:0] custom_pattern = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic        tone_on_o;
  logic        busy_res_o;
  logic [1:0]  status_o;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = bps_pkg::CfgDot;
  logic [15:0] cfg_wdata = '0;

  beep_tracker      tracker;
  bps_pkg::item_t   seen_req;
  bps_pkg::result_t seen_res;
  int               quiet_cycles = 0;
  logic             hold_off_req = 1'b0;

  beep_pattern_sequencer #(
    .MAX_SYMBOLS(MaxSymbols)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type),
    .pattern_sel_i   (pattern_sel),
    .custom_pattern_i(custom_pattern),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .tone_on_o       (tone_on_o),
    .busy_res_o      (busy_res_o),
    .status_o        (status_o),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Observe both handshakes and count cycles without progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        seen_req = {req_type, pattern_sel, custom_pattern};
        tracker.note_request(seen_req);
      end
      if (out_valid_o && out_ready) begin
        seen_res = {tone_on_o, busy_res_o, status_o};
        tracker.check_result(seen_res);
      end
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // A run that stops making progress ends as a failure.
  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("tb_top: done, errors");
    $finish;
  end

  // Result side: stall modes change every window; one long hold-off on request.
  initial begin : receiver
    int          left;
    ready_mode_e mode;
    left = 0;
    mode = ReadyAlways;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (left == 0) begin
          left = $urandom_range(200, 20);
          mode = ready_mode_e'($urandom_range(3, 0));
        end
        left--;
        case (mode)
          ReadyAlways:  out_ready <= 1'b1;
          ReadyHalf:    out_ready <= 1'($urandom_range(1, 0));
          ReadyQuarter: out_ready <= ($urandom_range(3, 0) == 0);
          default:      out_ready <= ((left % 8) < 2);
        endcase
      end
    end
  end

  // Symbol word of the given length with random dots, dashes and skips.
  function automatic logic [31:0] symbol_word(int len);
    logic [31:0]    word;
    bps_pkg::code_e c;
    word = $urandom;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9, 0))
        0, 1:    c = bps_pkg::CodeSkip;
        2, 3, 4: c = bps_pkg::CodeDash;
        default: c = bps_pkg::CodeDot;
      endcase
      word[2*i +: 2] = c;
    end
    if (len < bps_pkg::WordSymbols) word[2*len +: 2] = bps_pkg::CodeEnd;
    return word;
  endfunction

  function automatic bps_pkg::item_t random_request(int tick_pct);
    bps_pkg::item_t it;
    int             r;
    it.req_type       = bps_pkg::ReqTick;
    it.pattern_sel    = 8'($urandom);
    it.custom_pattern = $urandom;
    if ($urandom_range(99, 0) < tick_pct) return it;
    r = $urandom_range(99, 0);
    if (r < 40) begin
      it.req_type = bps_pkg::ReqBuiltin;
      if ($urandom_range(4, 0) != 0) it.pattern_sel = 8'($urandom_range(8, 0));
    end else if (r < 95) begin
      it.req_type = bps_pkg::ReqCustom;
      if ($urandom_range(5, 0) != 0) it.custom_pattern = symbol_word($urandom_range(16, 1));
    end else begin
      it.req_type = ReqIgnored;
    end
    return it;
  endfunction

  // Present one request and hold it until it is taken.
  task automatic offer(input logic [1:0] rt, input logic [7:0] psel, input logic [31:0] cust);
    in_valid       <= 1'b1;
    req_type       <= rt;
    pattern_sel    <= psel;
    custom_pattern <= cust;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Random requests in bursts with random gaps between them.
  task automatic run_random(input int count, input int tick_pct);
    bps_pkg::item_t it;
    int             burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(24, 1);
        pause_sender(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1));
      end
      burst--;
      it = random_request(tick_pct);
      offer(it.req_type, it.pattern_sel, it.custom_pattern);
    end
  endtask

  task automatic apply_settings(input logic [15:0] dot, input logic [15:0] dash,
                                input logic [15:0] gap);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= bps_pkg::CfgDot;
    cfg_wdata <= dot;
    tracker.set_register(bps_pkg::CfgDot, dot);
    @(posedge clk_i);
    cfg_idx   <= bps_pkg::CfgDash;
    cfg_wdata <= dash;
    tracker.set_register(bps_pkg::CfgDash, dash);
    @(posedge clk_i);
    cfg_idx   <= bps_pkg::CfgGap;
    cfg_wdata <= gap;
    tracker.set_register(bps_pkg::CfgGap, gap);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    bps_pkg::item_t it;
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All-skip word: one silent tick per symbol, then the end after the sixteenth.
    offer(bps_pkg::ReqCustom, 8'd0, 32'hFFFF_FFFF);
    repeat (17) offer(bps_pkg::ReqTick, 8'd0, 32'd0);

    // Request codes while idle and while playing, at the default durations.
    offer(ReqIgnored, 8'hFF, 32'hFFFF_FFFF);
    offer(bps_pkg::ReqTick, 8'd0, 32'd0);
    offer(bps_pkg::ReqBuiltin, 8'd9, 32'd0);
    offer(bps_pkg::ReqBuiltin, bps_pkg::CustomSlot, 32'd0);
    offer(bps_pkg::ReqCustom, 8'd0, 32'hFFFF_FFFC);
    offer(bps_pkg::ReqBuiltin, 8'd1, 32'd0);
    offer(bps_pkg::ReqBuiltin, bps_pkg::CustomSlot, 32'd0);
    offer(bps_pkg::ReqBuiltin, 8'hFF, 32'd0);
    offer(bps_pkg::ReqCustom, 8'd0, 32'h0000_0005);
    offer(ReqIgnored, 8'd0, 32'd0);
    run_random(150, 92);

    // Short durations; the receiver holds off while the sender keeps pushing.
    apply_settings(16'd1, 16'd2, 16'd1);
    hold_off_req = 1'b1;
    repeat (40) begin
      it = random_request(70);
      offer(it.req_type, it.pattern_sel, it.custom_pattern);
    end
    run_random(250, 70);
    drain();
    run_random(250, 70);

    // Zero durations end each phase on the next tick.
    apply_settings(16'd0, 16'd0, 16'd0);
    run_random(300, 70);

    apply_settings(16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)),
                   16'($urandom_range(6, 1)));
    run_random(500, 75);

    apply_settings(16'd2, 16'd5, 16'd1);
    run_random(250, 80);

    // Full-scale durations last, since a started pattern outlives the run.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(150, 80);

    drain();
    repeat (8) @(posedge clk_i);
    $display("tb_top: %0d results checked, %0d patterns started, %0d busy and %0d bad-parameter",
             tracker.checked, tracker.started, tracker.busy_rejects, tracker.param_rejects);
    $display("tb_top: %0d results with the buzzer on, six duration settings from zero to full",
             tracker.tone_results);
    if (tracker.mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* beep_pattern_sequencer.f */
+incdir+rtl
rtl/bps_pkg.sv
rtl/bps_in_stage.sv
rtl/bps_core.sv
rtl/bps_out_stage.sv
rtl/beep_pattern_sequencer.sv
tb/tb_top.sv
